>>> hw/rtl/arc_pkg.sv
// package for the address range coalescer
// payload structs, controller states and control/status structs; no dependencies
`timescale 1ns / 1ps
package arc_pkg;

    localparam int unsigned AddrW  = 24;
    localparam int unsigned LabelW = 16;
    localparam int unsigned CountW = 16;
    localparam int unsigned EndW   = 25;
    localparam int unsigned EntryW = LabelW + AddrW + CountW + 1;
    localparam logic [AddrW-1:0] SpanReset = 24'd250;

    typedef struct packed {
        logic [LabelW-1:0] tag_label;
        logic [AddrW-1:0]  start_addr;
        logic [CountW-1:0] byte_count;
        logic              may_merge;
        logic              group_end;
    } t_in_word;

    typedef struct packed {
        logic [LabelW-1:0] out_label;
        logic [AddrW-1:0]  batch_start;
        logic [AddrW-1:0]  batch_length;
        logic              batch_last;
        logic              run_last;
    } t_out_word;

    typedef struct packed {
        logic [LabelW-1:0] label;
        logic [AddrW-1:0]  addr;
        logic [CountW-1:0] count;
        logic              merge;
    } t_entry;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SHIFT,
        ST_SCAN_RD,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;       // take the new word, read the top entry
        logic shift_step; // insertion: move entry up one
        logic ins_write;  // insertion: write new entry at the hole
        logic scan_start; // merge pass: read entry 0
        logic scan_step;  // merge pass: consume one entry
        logic emit_start; // output pass: read entry 0
        logic emit_step;  // output pass: consume one entry
    } t_cmd;

    typedef struct packed {
        logic shift_done; // insertion position found
        logic last;       // walk is at the last held entry
        logic full;
    } t_status;

endpackage

>>> hw/rtl/arc_ram.sv
// generic ram, one write port and one registered read port with read enable
// no dependencies
`timescale 1ns / 1ps
module arc_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end
    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/arc_ctrl.sv
// controller state machine for the coalescer
// depends on arc_pkg
`timescale 1ns / 1ps
module arc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_group_end,
    input  logic             i_out_stall,
    input  arc_pkg::t_status i_status,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output arc_pkg::t_cmd    o_cmd
);
    arc_pkg::t_state r_state, n_state;
    logic r_pend_end, n_pend_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arc_pkg::ST_LOAD;
            r_pend_end <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_end <= n_pend_end;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pend_end  = r_pend_end;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            arc_pkg::ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_pend_end = i_group_end;
                    if (!i_status.full) begin
                        o_cmd.load = 1'b1;
                        n_state    = arc_pkg::ST_SHIFT;
                    end else if (i_group_end) begin
                        n_state = arc_pkg::ST_SCAN_RD;
                    end
                end
            end
            arc_pkg::ST_SHIFT: begin
                if (i_status.shift_done) begin
                    o_cmd.ins_write = 1'b1;
                    n_state = r_pend_end ? arc_pkg::ST_SCAN_RD : arc_pkg::ST_LOAD;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            arc_pkg::ST_SCAN_RD: begin
                o_cmd.scan_start = 1'b1;
                n_state = arc_pkg::ST_SCAN;
            end
            arc_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.last) begin
                    n_state = arc_pkg::ST_EMIT_RD;
                end
            end
            arc_pkg::ST_EMIT_RD: begin
                o_cmd.emit_start = 1'b1;
                n_state = arc_pkg::ST_EMIT;
            end
            arc_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_status.last) begin
                        n_state = arc_pkg::ST_LOAD;
                    end
                end
            end
            default: n_state = arc_pkg::ST_LOAD;
        endcase
    end
endmodule

>>> hw/rtl/arc_dp.sv
// datapath: sorted request store, merge pass and batch table
// depends on arc_pkg and arc_ram
`timescale 1ns / 1ps
module arc_dp #(
    parameter int unsigned MaxRequests = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  arc_pkg::t_in_word         i_word,
    input  logic [arc_pkg::AddrW-1:0] i_max_span,
    input  arc_pkg::t_cmd             i_cmd,
    output arc_pkg::t_status          o_status,
    output arc_pkg::t_out_word        o_word
);
    localparam int unsigned IdxW = $clog2(MaxRequests);
    localparam int unsigned CntW = $clog2(MaxRequests + 1);
    localparam int unsigned AW   = arc_pkg::AddrW;
    localparam int unsigned EW   = arc_pkg::EndW;

    logic [CntW-1:0] r_count;
    logic [IdxW-1:0] r_ptr;     // hole during insertion, entry in read data during walks
    arc_pkg::t_entry r_new;
    logic [AW-1:0]   r_bbeg;
    logic [EW-1:0]   r_bend;
    logic            r_first_merge;
    logic [IdxW-1:0] r_bidx;    // id of the open batch
    logic [IdxW-1:0] r_bid;     // batch id of the word on the output

    logic            st_we, st_re;
    logic [IdxW-1:0] st_waddr, st_raddr;
    arc_pkg::t_entry st_wdata, st_rdata;

    // one bit per position: entry opens a new batch
    logic            fl_we, fl_re;
    logic [IdxW-1:0] fl_waddr, fl_raddr;
    logic [0:0]      fl_wdata, fl_rdata;

    // batch start and length per batch id
    logic            bt_we, bt_re;
    logic [IdxW-1:0] bt_waddr, bt_raddr;
    logic [2*AW-1:0] bt_wdata, bt_rdata;

    logic [EW-1:0]   ne, span_val, cur_end;
    logic [AW-1:0]   cur_beg;
    logic [IdxW-1:0] cur_id;
    logic            join_b, last, blast;

    arc_ram #(.Width(arc_pkg::EntryW), .Depth(MaxRequests)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_re(st_re), .i_raddr(st_raddr), .o_rdata(st_rdata)
    );

    arc_ram #(.Width(1), .Depth(MaxRequests)) u_flag (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_waddr), .i_wdata(fl_wdata),
        .i_re(fl_re), .i_raddr(fl_raddr), .o_rdata(fl_rdata)
    );

    arc_ram #(.Width(2*AW), .Depth(MaxRequests)) u_btab (
        .i_clk(i_clk), .i_we(bt_we), .i_waddr(bt_waddr), .i_wdata(bt_wdata),
        .i_re(bt_re), .i_raddr(bt_raddr), .o_rdata(bt_rdata)
    );

    // status and output word
    always_comb begin
        last  = (CntW'(r_ptr) + CntW'(1)) == r_count;
        blast = last || fl_rdata[0];
        o_status.shift_done = (r_ptr == '0) || (st_rdata.addr <= r_new.addr);
        o_status.last       = last;
        o_status.full       = r_count == CntW'(MaxRequests);
        o_word.out_label    = st_rdata.label;
        o_word.batch_start  = bt_rdata[2*AW-1:AW];
        o_word.batch_length = bt_rdata[AW-1:0];
        o_word.batch_last   = blast;
        o_word.run_last     = last;
    end

    // merge decision for the entry in read data
    always_comb begin
        ne       = EW'(st_rdata.addr) + EW'(st_rdata.count);
        span_val = ne - EW'(r_bbeg);
        join_b   = (r_ptr != '0) && st_rdata.merge && r_first_merge &&
                   (span_val <= EW'(i_max_span));
        cur_beg  = join_b ? r_bbeg : st_rdata.addr;
        cur_end  = (join_b && !(ne > r_bend)) ? r_bend : ne;
        cur_id   = (r_ptr == '0) ? '0 : r_bidx + IdxW'(!join_b);
    end

    // ram ports
    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_ptr;
        st_wdata = st_rdata;
        st_re    = 1'b0;
        st_raddr = r_ptr;
        if (i_cmd.load) begin
            st_re    = 1'b1;
            st_raddr = IdxW'(r_count - CntW'(1));
        end
        if (i_cmd.shift_step) begin
            st_we    = 1'b1;
            st_re    = 1'b1;
            st_raddr = r_ptr - IdxW'(2);
        end
        if (i_cmd.ins_write) begin
            st_we    = 1'b1;
            st_wdata = r_new;
        end
        if (i_cmd.scan_start || i_cmd.emit_start) begin
            st_re    = 1'b1;
            st_raddr = '0;
        end
        if (i_cmd.scan_step || i_cmd.emit_step) begin
            st_re    = 1'b1;
            st_raddr = r_ptr + IdxW'(1);
        end

        fl_we    = i_cmd.scan_step;
        fl_waddr = r_ptr;
        fl_wdata = !join_b;
        fl_re    = i_cmd.emit_start || i_cmd.emit_step;
        fl_raddr = i_cmd.emit_start ? IdxW'(1) : r_ptr + IdxW'(2);

        bt_we    = i_cmd.scan_step;
        bt_waddr = cur_id;
        bt_wdata = {cur_beg, AW'(cur_end - EW'(cur_beg))};
        bt_re    = i_cmd.emit_start || i_cmd.emit_step;
        bt_raddr = i_cmd.emit_start ? '0 : r_bid + IdxW'(blast);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_ptr         <= '0;
            r_new         <= '0;
            r_bbeg        <= '0;
            r_bend        <= '0;
            r_first_merge <= 1'b0;
            r_bidx        <= '0;
            r_bid         <= '0;
        end else begin
            if (i_cmd.load) begin
                r_new <= {i_word.tag_label, i_word.start_addr,
                          i_word.byte_count, i_word.may_merge};
                r_ptr <= IdxW'(r_count);
            end
            if (i_cmd.shift_step) begin
                r_ptr <= r_ptr - IdxW'(1);
            end
            if (i_cmd.ins_write) begin
                r_count <= r_count + CntW'(1);
            end
            if (i_cmd.scan_start) begin
                r_ptr <= '0;
            end
            if (i_cmd.scan_step) begin
                r_ptr  <= r_ptr + IdxW'(1);
                r_bbeg <= cur_beg;
                r_bend <= cur_end;
                r_bidx <= cur_id;
                if (!join_b) begin
                    r_first_merge <= st_rdata.merge;
                end
            end
            if (i_cmd.emit_start) begin
                r_ptr <= '0;
                r_bid <= '0;
            end
            if (i_cmd.emit_step) begin
                r_ptr <= r_ptr + IdxW'(1);
                r_bid <= r_bid + IdxW'(blast);
                if (last) begin
                    r_count <= '0;
                end
            end
        end
    end
endmodule

>>> hw/rtl/address_range_coalescer.sv
// top level of the address range coalescer
// load: each word is taken, then the insertion shift moves held entries up one by one
// until its place is found; a group end then runs one merge walk and one output walk
// a group end word arriving with the store full goes straight to the merge walk
// output walk: one result word per cycle when not stalled; input stalled meanwhile
// reset: synchronous active low, store empty, max_span back to 250
`timescale 1ns / 1ps
module address_range_coalescer #(
    parameter int unsigned MAX_REQUESTS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  arc_pkg::t_in_word         i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output arc_pkg::t_out_word        o_out_word,
    input  logic                      i_cfg_we,
    input  logic [arc_pkg::AddrW-1:0] i_cfg_data
);
    logic [arc_pkg::AddrW-1:0] r_max_span;
    arc_pkg::t_cmd    cmd;
    arc_pkg::t_status status;

    // span register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_span <= arc_pkg::SpanReset;
        end else if (i_cfg_we) begin
            r_max_span <= i_cfg_data;
        end
    end

    // sequencing: load, insertion shift, merge walk, output walk
    arc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_group_end(i_in_word.group_end), .i_out_stall(i_out_stall),
        .i_status(status), .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
        .o_cmd(cmd)
    );

    // sorted store, batch flags and batch table
    arc_dp #(.MaxRequests(MAX_REQUESTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(i_in_word),
        .i_max_span(r_max_span), .i_cmd(cmd), .o_status(status), .o_word(o_out_word)
    );

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed under stall");

    // no input taken while results are shown
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && !o_in_stall))
        else $error("input and output both open");
endmodule
